[hw/rtl/tbs_pkg.sv]
// Shared types and constants for the trimmed bounding sphere block.
// Used by the top level, tbs_ctrl and tbs_dp; depends on nothing.
`default_nettype none
package tbs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int RMC_W        = 11;

  localparam logic [31:0]      BIAS        = 32'h8000_0000;
  localparam logic [RMC_W-1:0] RMC_RESET   = RMC_W'(20);
  localparam logic [31:0]      MINR_RESET  = 32'(1) << FRAC_BITS;
  localparam logic [4:0]       TOP_BIT     = 5'd31;
  localparam logic [4:0]       ROOT_STEPS  = 5'd31;
  localparam logic [63:0]      ROOT_ONE    = 64'(1) << 62;

  // Configuration register indexes
  localparam logic REG_RMC  = 1'b0;
  localparam logic REG_MINR = 1'b1;

  // Frame status codes
  localparam logic [1:0] FS_VALID = 2'd0;
  localparam logic [1:0] FS_NONE  = 2'd1;
  localparam logic [1:0] FS_OVF   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_PASS, S_DRAIN, S_UPDATE, S_MUL, S_ROOT_PREP, S_ROOT, S_OUT
  } state_t;

  // How the end of a scene is resolved
  typedef enum logic [2:0] {
    DEC_OVF, DEC_NONE, DEC_TRIM, DEC_REF, DEC_FULL
  } dec_t;

  typedef struct packed {
    logic              load;
    logic              sel_start;
    logic              take_bounds;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              pass_end;
    logic [4:0]        bit_idx;
    logic              mul_en;
    logic [1:0]        mul_axis;
    logic              acc_en;
    logic              root_init;
    logic              root_step;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    dec_t             dec;
    logic [CNT_W-1:0] count;
    logic             out_busy;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/trimmed_bounding_sphere_top.sv]
// Top level of the trimmed bounding sphere block: controller plus datapath.
// Depends on tbs_pkg, tbs_ctrl, tbs_dp, tbs_ram.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata x,y,z; tuser finite,referenced; tlast last
//   m_*      out  m_tvalid/m_tready  tdata cx,cy,cz,radius; tuser frame_status
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A vertex that is not last is accepted while idle. After a last vertex the input
// stalls; with trimming the block makes 32 read sweeps of the coordinate stores
// over the n stored vertices, then squares the extents and takes the root. Without
// trimming it skips the sweeps, and when no frame is made it goes straight to the
// output. The frame is loaded once the output register is free. Reset is synchronous;
// no clearing pass is needed. A finished frame waits there while new vertices are accepted.
`default_nettype none
module trimmed_bounding_sphere_top import tbs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // coord_x, coord_y, coord_z
  input  wire logic [1:0]   s_tuser,   // coords_finite, referenced
  input  wire logic         s_tlast,   // last_vertex
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // center_x, center_y, center_z, radius
  output logic [1:0]        m_tuser,   // frame_status
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

[hw/rtl/tbs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tbs_ctrl.sv]
// Sequencer for the trimmed bounding sphere: load, selection passes,
// squaring, root and output. Depends on tbs_pkg.
`default_nettype none
module tbs_ctrl import tbs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [4:0]       bit_idx, bit_idx_next;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      bit_idx <= bit_idx_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    bit_idx_next = bit_idx;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_addr  = cnt[ADDR_W-1:0];
    cmd.bit_idx  = bit_idx;
    cmd.mul_axis = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_next = '0;
        unique case (stat.dec)
          DEC_TRIM: begin
            cmd.sel_start = 1'b1;
            bit_idx_next  = TOP_BIT;
            state_next    = S_PASS;
          end
          DEC_REF, DEC_FULL: begin
            cmd.take_bounds = 1'b1;
            state_next      = S_MUL;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_PASS: begin
        cmd.rd_en = 1'b1;
        if (cnt == stat.count - CNT_W'(1)) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_DRAIN: state_next = S_UPDATE;
      S_UPDATE: begin
        cmd.pass_end = 1'b1;
        cnt_next     = '0;
        if (bit_idx == 5'd0) begin
          state_next = S_MUL;
        end else begin
          bit_idx_next = bit_idx - 5'd1;
          state_next   = S_PASS;
        end
      end
      S_MUL: begin
        cmd.mul_en = (cnt < CNT_W'(3));
        cmd.acc_en = (cnt != '0);
        if (cnt == CNT_W'(3)) begin
          state_next = S_ROOT_PREP;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_ROOT_PREP: begin
        cmd.root_init = 1'b1;
        bit_idx_next  = ROOT_STEPS;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (bit_idx == 5'd0) begin
          state_next = S_OUT;
        end else begin
          bit_idx_next = bit_idx - 5'd1;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/tbs_dp.sv]
// Datapath: vertex stores, running bounds, radix selection counters,
// squared-extent sum, integer root and output register. Depends on tbs_pkg, tbs_ram.
`default_nettype none
module tbs_dp import tbs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [95:0]       in_data,
  input  wire logic [1:0]        in_user,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output logic [127:0]           m_tdata,
  output logic [1:0]             m_tuser
);

  logic [RMC_W-1:0] rmc;
  logic [31:0]      minr;
  logic [CNT_W-1:0] ref_count;
  logic [31:0]      ref_lo [3];
  logic [31:0]      ref_hi [3];
  logic [31:0]      full_lo [3];
  logic [31:0]      full_hi [3];
  logic             full_seen, ref_inv, any_inv, overflow;
  dec_t             dec;

  logic [31:0]      v [3];
  logic             finite, refd, can_store;
  logic [31:0]      rdv [3];
  logic             dvalid;
  logic [31:0]      hmask;

  logic [31:0]      pre [6];
  logic [CNT_W-1:0] kk [6];
  logic [CNT_W-1:0] cc [6];
  logic [CNT_W-1:0] lo_rank;

  logic [31:0]      e_sel;
  logic [63:0]      prod;
  logic [63:0]      quarter;
  logic [3:0]       low;
  logic [63:0]      rv, res, one, trial;
  logic [31:0]      rad;
  logic [32:0]      csum [3];

  assign finite    = in_user[0];
  assign refd      = in_user[1];
  assign can_store = (32'(ref_count) < 32'(MAX_VERTICES));
  assign lo_rank   = ref_count >> 2;
  assign hmask     = ~(32'hFFFF_FFFF >> (5'd31 - cmd.bit_idx));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign v[a] = in_data[32*a +: 32] ^ BIAS;
    tbs_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_store (
      .clk   (clk),
      .we    (cmd.load && finite && refd && can_store),
      .waddr (ref_count[ADDR_W-1:0]),
      .wdata (v[a]),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (rdv[a])
    );
    assign csum[a] = {1'b0, pre[a]} + {1'b0, pre[a+3]};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rmc  <= RMC_RESET;
      minr <= MINR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RMC:  rmc  <= cfg_data[RMC_W-1:0];
        REG_MINR: minr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scene accumulation; clear when the frame is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      ref_count <= '0;
      full_seen <= 1'b0;
      ref_inv   <= 1'b0;
      any_inv   <= 1'b0;
      overflow  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        ref_lo[a]  <= '1;
        ref_hi[a]  <= '0;
        full_lo[a] <= '1;
        full_hi[a] <= '0;
      end
    end else if (cmd.load) begin
      if (!finite) begin
        any_inv <= 1'b1;
        if (refd) ref_inv <= 1'b1;
      end else begin
        full_seen <= 1'b1;
        for (int a = 0; a < 3; a++) begin
          if (v[a] < full_lo[a]) full_lo[a] <= v[a];
          if (v[a] > full_hi[a]) full_hi[a] <= v[a];
          if (refd && v[a] < ref_lo[a]) ref_lo[a] <= v[a];
          if (refd && v[a] > ref_hi[a]) ref_hi[a] <= v[a];
        end
        if (refd) begin
          if (can_store) ref_count <= ref_count + CNT_W'(1);
          else overflow <= 1'b1;
        end
      end
    end
  end

  // Scene decision
  always_comb begin
    priority if (overflow)                        dec = DEC_OVF;
    else if (ref_inv)                             dec = DEC_NONE;
    else if (ref_count != '0 && 32'(ref_count) >= 32'(rmc)) dec = DEC_TRIM;
    else if (ref_count != '0)                     dec = DEC_REF;
    else if (any_inv || !full_seen)               dec = DEC_NONE;
    else                                          dec = DEC_FULL;
  end
  assign stat.dec      = dec;
  assign stat.count    = ref_count;
  assign stat.out_busy = m_tvalid && !m_tready;

  // Read data valid in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) dvalid <= 1'b0;
    else     dvalid <= cmd.rd_en;
  end

  // Radix selection: per bit, count entries under the prefix with a zero there
  always_ff @(posedge clk) begin
    if (cmd.sel_start) begin
      for (int j = 0; j < 6; j++) begin
        pre[j] <= '0;
        cc[j]  <= '0;
        kk[j]  <= (j < 3) ? lo_rank : ref_count - lo_rank - CNT_W'(1);
      end
    end else if (cmd.take_bounds) begin
      for (int a = 0; a < 3; a++) begin
        pre[a]   <= (dec == DEC_FULL) ? full_lo[a] : ref_lo[a];
        pre[a+3] <= (dec == DEC_FULL) ? full_hi[a] : ref_hi[a];
      end
    end else if (cmd.pass_end) begin
      for (int j = 0; j < 6; j++) begin
        cc[j] <= '0;
        if (kk[j] >= cc[j]) begin
          kk[j]               <= kk[j] - cc[j];
          pre[j][cmd.bit_idx] <= 1'b1;
        end
      end
    end else if (dvalid) begin
      for (int a = 0; a < 3; a++) begin
        if (((rdv[a] ^ pre[a]) & hmask) == '0 && !rdv[a][cmd.bit_idx])
          cc[a] <= cc[a] + CNT_W'(1);
        if (((rdv[a] ^ pre[a+3]) & hmask) == '0 && !rdv[a][cmd.bit_idx])
          cc[a+3] <= cc[a+3] + CNT_W'(1);
      end
    end
  end

  // Extent of the selected axis
  always_comb begin
    unique case (cmd.mul_axis)
      2'd0:    e_sel = pre[3] - pre[0];
      2'd1:    e_sel = pre[4] - pre[1];
      default: e_sel = pre[5] - pre[2];
    endcase
  end

  // Square one extent a cycle, then sum quarters and low bits
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= 64'(e_sel) * 64'(e_sel);
    if (cmd.sel_start || cmd.take_bounds) begin
      quarter <= '0;
      low     <= '0;
    end else if (cmd.acc_en) begin
      quarter <= quarter + (prod >> 2);
      low     <= low + {2'b00, prod[1:0]};
    end
  end

  // Integer square root, digit by digit
  assign trial = res + one;
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rv  <= quarter + 64'(low >> 2);
      res <= '0;
      one <= ROOT_ONE;
    end else if (cmd.root_step) begin
      if (rv >= trial) begin
        rv  <= rv - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
    end
  end

  assign rad = (res[31:0] < minr) ? minr : res[31:0];

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (dec)
        DEC_OVF: begin
          m_tuser <= FS_OVF;
          m_tdata <= '0;
        end
        DEC_NONE: begin
          m_tuser <= FS_NONE;
          m_tdata <= '0;
        end
        default: begin
          m_tuser <= FS_VALID;
          m_tdata <= {rad, csum[2][32:1] ^ BIAS, csum[1][32:1] ^ BIAS,
                      csum[0][32:1] ^ BIAS};
        end
      endcase
    end
  end

endmodule
`default_nettype wire
